### rtl/core/nfdf_pkg.sv
package nfdf_pkg;

  // Frame store geometry: 8192 bytes, two pixels per byte
  localparam int STORE_DEPTH = 8192;
  localparam int ADDR_W      = 13;

  // Operation codes carried on the input tuser
  localparam logic [2:0] FUNC_WRITE = 3'd0;
  localparam logic [2:0] FUNC_READ  = 3'd1;
  localparam logic [2:0] FUNC_MARK  = 3'd2;
  localparam logic [2:0] FUNC_START = 3'd3;
  localparam logic [2:0] FUNC_NEXT  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Store access that a request still owes after the front stage
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_FLUSH
  } op_t;

  // Front stage result, finished by the back stage with store data
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic              hi;
    logic [3:0]        pixel_value;
    logic [1:0]        status;
    logic              dirty_flag;
    logic              byte_valid;
    logic [5:0]        flush_row;
    logic [5:0]        column_unit;
    logic              row_start;
    logic              flush_last;
  } front_req_t;

  // Store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

### rtl/core/nfdf_ram.sv
module nfdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; a read beside a write sees old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/nfdf_front.sv
module nfdf_front
  import nfdf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        func,
  input  logic [9:0]        x_pos,
  input  logic [7:0]        y_pos,
  input  logic [9:0]        width,
  input  logic [7:0]        height,
  input  logic [3:0]        pixel_value,
  output front_req_t        req
);

  localparam int ROW_BYTES = (SCREEN_WIDTH + 1) / 2;

  // Dirty rectangle, inclusive edges
  logic              pending_dirty, pending_dirty_next;
  logic signed [9:0] rect_left, rect_left_next;
  logic signed [7:0] rect_top, rect_top_next;
  logic signed [10:0] rect_right, rect_right_next;
  logic signed [8:0] rect_bottom, rect_bottom_next;

  // Flush walker
  logic       flush_active, flush_active_next;
  logic [8:0] flush_cursor, flush_cursor_next;
  logic [8:0] flush_span, flush_span_next;
  logic [7:0] flush_first, flush_first_next;
  logic [6:0] flush_unit, flush_unit_next;
  logic [7:0] flush_line, flush_line_next;
  logic [6:0] flush_bottom, flush_bottom_next;

  logic signed [9:0]  xs, ws;
  logic signed [7:0]  ys, hs;
  logic               on_screen;
  logic signed [10:0] mark_right;
  logic signed [8:0]  mark_bottom;
  logic [8:0]         x0;
  logic [6:0]         y0;
  logic signed [10:0] x1;
  logic signed [8:0]  y1;
  logic               rect_empty;
  logic [6:0]         unit_new;
  logic [7:0]         bstart;
  logic [8:0]         bend;
  logic [9:0]         cur_inc;
  logic [7:0]         addr_row;
  logic [9:0]         addr_col;
  logic [15:0]        addr_full;

  assign xs = $signed(x_pos);
  assign ys = $signed(y_pos);
  assign ws = $signed(width);
  assign hs = $signed(height);

  assign on_screen = !x_pos[9] && ({1'b0, x_pos} < 11'(SCREEN_WIDTH))
                  && !y_pos[7] && ({1'b0, y_pos} < 9'(SCREEN_HEIGHT));

  assign mark_right  = 11'(xs) + 11'(ws) - 11'sd1;
  assign mark_bottom = 9'(ys) + 9'(hs) - 9'sd1;

  // Clamp the pending rectangle to the screen
  assign x0 = rect_left[9] ? 9'd0 : rect_left[8:0];
  assign y0 = rect_top[7] ? 7'd0 : rect_top[6:0];
  assign x1 = (rect_right > $signed(11'(SCREEN_WIDTH - 1)))
              ? $signed(11'(SCREEN_WIDTH - 1)) : rect_right;
  assign y1 = (rect_bottom > $signed(9'(SCREEN_HEIGHT - 1)))
              ? $signed(9'(SCREEN_HEIGHT - 1)) : rect_bottom;
  assign rect_empty = ($signed({2'b00, x0}) > x1) || ($signed({2'b00, y0}) > y1);

  // Round left edge to four pixels and make the byte span even
  assign unit_new = x0[8:2];
  assign bstart   = {unit_new, 1'b0};
  assign bend     = x1[1] ? {1'b0, x1[8:1]} : ({1'b0, x1[8:1]} + 9'd1);

  assign cur_inc = {1'b0, flush_cursor} + 10'd1;

  // Byte address: row times row pitch plus byte column, wrapped at store end
  always_comb begin
    if (func == FUNC_NEXT) begin
      addr_row = flush_line;
      addr_col = 10'(flush_first) + 10'(flush_cursor);
    end else begin
      addr_row = {1'b0, y_pos[6:0]};
      addr_col = {1'b0, x_pos[9:1]};
    end
    addr_full = 16'(addr_row) * 16'(ROW_BYTES) + 16'(addr_col);
  end

  // Decode the request and work out the next state
  always_comb begin
    pending_dirty_next = pending_dirty;
    rect_left_next     = rect_left;
    rect_top_next      = rect_top;
    rect_right_next    = rect_right;
    rect_bottom_next   = rect_bottom;
    flush_active_next  = flush_active;
    flush_cursor_next  = flush_cursor;
    flush_span_next    = flush_span;
    flush_first_next   = flush_first;
    flush_unit_next    = flush_unit;
    flush_line_next    = flush_line;
    flush_bottom_next  = flush_bottom;

    req             = '0;
    req.op          = OP_NONE;
    req.addr        = addr_full[ADDR_W-1:0];
    req.hi          = !x_pos[0];
    req.pixel_value = pixel_value;
    req.status      = ST_OK;

    case (func)
      FUNC_WRITE, FUNC_READ: begin
        if (!on_screen) begin
          req.status = ST_RANGE;
        end else begin
          req.op = (func == FUNC_WRITE) ? OP_WRITE : OP_READ;
        end
      end
      FUNC_MARK: begin
        if (!width[9] && (width != '0) && !height[7] && (height != '0)) begin
          if (!pending_dirty) begin
            pending_dirty_next = 1'b1;
            rect_left_next     = xs;
            rect_top_next      = ys;
            rect_right_next    = mark_right;
            rect_bottom_next   = mark_bottom;
          end else begin
            if (rect_left > xs) rect_left_next = xs;
            if (rect_top > ys) rect_top_next = ys;
            if (rect_right < mark_right) rect_right_next = mark_right;
            if (rect_bottom < mark_bottom) rect_bottom_next = mark_bottom;
          end
        end
      end
      FUNC_START: begin
        if (!pending_dirty) begin
          req.status = ST_EMPTY;
        end else begin
          pending_dirty_next = 1'b0;
          if (rect_empty) begin
            flush_active_next = 1'b0;
            req.status        = ST_EMPTY;
          end else begin
            flush_unit_next   = unit_new;
            flush_first_next  = bstart;
            flush_span_next   = bend - 9'(bstart) + 9'd1;
            flush_cursor_next = '0;
            flush_line_next   = {1'b0, y0};
            flush_bottom_next = y1[6:0];
            flush_active_next = 1'b1;
          end
        end
      end
      FUNC_NEXT: begin
        if (!flush_active) begin
          req.status = ST_EMPTY;
        end else begin
          req.op          = OP_FLUSH;
          req.byte_valid  = 1'b1;
          req.flush_row   = flush_line[5:0];
          req.column_unit = flush_unit[5:0];
          req.row_start   = (flush_cursor == '0);
          req.flush_last  = (cur_inc == {1'b0, flush_span})
                         && (flush_line == {1'b0, flush_bottom});
          if (cur_inc >= {1'b0, flush_span}) begin
            flush_cursor_next = '0;
            flush_line_next   = flush_line + 8'd1;
            if ((flush_line + 8'd1) > {1'b0, flush_bottom}) begin
              flush_active_next = 1'b0;
            end
          end else begin
            flush_cursor_next = cur_inc[8:0];
          end
        end
      end
      default: begin
        req.status = ST_OK;
      end
    endcase

    req.dirty_flag = pending_dirty_next;
  end

  // Hold state; advance only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_dirty <= 1'b0;
      rect_left     <= '0;
      rect_top      <= '0;
      rect_right    <= '0;
      rect_bottom   <= '0;
      flush_active  <= 1'b0;
      flush_cursor  <= '0;
      flush_span    <= '0;
      flush_first   <= '0;
      flush_unit    <= '0;
      flush_line    <= '0;
      flush_bottom  <= '0;
    end else if (accept) begin
      pending_dirty <= pending_dirty_next;
      rect_left     <= rect_left_next;
      rect_top      <= rect_top_next;
      rect_right    <= rect_right_next;
      rect_bottom   <= rect_bottom_next;
      flush_active  <= flush_active_next;
      flush_cursor  <= flush_cursor_next;
      flush_span    <= flush_span_next;
      flush_first   <= flush_first_next;
      flush_unit    <= flush_unit_next;
      flush_line    <= flush_line_next;
      flush_bottom  <= flush_bottom_next;
    end
  end

endmodule

### rtl/core/nfdf_back.sv
module nfdf_back
  import nfdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  front_req_t  req,
  input  logic [7:0]  ram_rdata,
  input  logic        m_axis_tready,
  output logic        advance,
  output mem_wr_t     wr,
  output logic        m_axis_tvalid,
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic              s1_valid;
  front_req_t        s1;
  logic              byp_valid;
  logic [ADDR_W-1:0] byp_addr;
  logic [7:0]        byp_data;
  logic [7:0]        cur_byte;
  logic [7:0]        merged;
  logic [3:0]        rd_pixel;
  logic [7:0]        out_byte;
  logic              out_free;

  // Result register can take a new value when empty or being drained
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Stage moves when empty or when the result register frees up
  assign advance = !s1_valid || out_free;

  // Take the last write when it hit the address read alongside it
  always_comb begin
    cur_byte = (byp_valid && (byp_addr == s1.addr)) ? byp_data : ram_rdata;
    merged   = s1.hi ? {s1.pixel_value, cur_byte[3:0]} : {cur_byte[7:4], s1.pixel_value};
    rd_pixel = (s1.op == OP_READ) ? (s1.hi ? cur_byte[7:4] : cur_byte[3:0]) : 4'd0;
    out_byte = (s1.op == OP_FLUSH) ? cur_byte : 8'd0;
    wr.en    = s1_valid && advance && (s1.op == OP_WRITE);
    wr.addr  = s1.addr;
    wr.data  = merged;
  end

  // Control: stage and result valid, bypass valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      byp_valid     <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= accept;
      end
      if (out_free) begin
        m_axis_tvalid <= s1_valid;
      end
      if (wr.en) begin
        byp_valid <= 1'b1;
      end
    end
  end

  // Payload: stage request, result fields, last write
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= req;
    end
    if (advance && s1_valid) begin
      m_axis_tdata <= {3'd0, s1.row_start, out_byte, s1.column_unit, s1.flush_row,
                       s1.byte_valid, s1.dirty_flag, rd_pixel, s1.status};
      m_axis_tlast <= s1.flush_last;
    end
    if (wr.en) begin
      byp_addr <= wr.addr;
      byp_data <= wr.data;
    end
  end

endmodule

### rtl/core/nibble_framebuffer_dirty_flush.sv
// A request is held in the stage register after the edge that accepts it, then moves
// into the result register when that is free, and is presented from there.
// Throughput: one request per cycle while results are taken; the store has one
// read and one write port, and a pixel write is a read-modify-write spread over
// both stages. Reset: rst is synchronous; afterwards the 8192-byte store is zeroed
// one byte per cycle, and s_axis_tready stays low until the clearing is done.
module nibble_framebuffer_dirty_flush
  import nfdf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // x_pos, y_pos, width, height, pixel_value
  input  logic [2:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status, read_pixel, dirty_flag, byte_valid,
                                      // flush_row, column_unit, flush_byte, row_start
  output logic        m_axis_tlast    // flush_last
);

  logic              accept;
  logic              advance;
  front_req_t        req;
  mem_wr_t           back_wr;
  logic [7:0]        ram_rdata;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;

  assign s_axis_tready = !clearing && advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Zero the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  assign ram_we    = clearing || back_wr.en;
  assign ram_waddr = clearing ? clr_addr : back_wr.addr;
  assign ram_wdata = clearing ? 8'd0 : back_wr.data;

  nfdf_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (s_axis_tuser),
    .x_pos       (s_axis_tdata[9:0]),
    .y_pos       (s_axis_tdata[17:10]),
    .width       (s_axis_tdata[27:18]),
    .height      (s_axis_tdata[35:28]),
    .pixel_value (s_axis_tdata[39:36]),
    .req         (req)
  );

  nfdf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (req.addr),
    .rdata (ram_rdata)
  );

  nfdf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .req           (req),
    .ram_rdata     (ram_rdata),
    .m_axis_tready (m_axis_tready),
    .advance       (advance),
    .wr            (back_wr),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### tb/nfdf_result_checker.sv
module nfdf_result_checker
  import nfdf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // x_pos, y_pos, width, height, pixel_value
  input  logic [2:0]  s_axis_tuser,   // func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // status, read_pixel, dirty_flag, byte_valid,
                                      // flush_row, column_unit, flush_byte, row_start
  input  logic        m_axis_tlast,   // flush_last
  output int          fail_count,
  output int          owed_count
);

  localparam int ROW_BYTES = (SCREEN_WIDTH + 1) / 2;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] read_pixel;
    logic       dirty_flag;
    logic       byte_valid;
    logic [5:0] flush_row;
    logic [5:0] column_unit;
    logic [7:0] flush_byte;
    logic       row_start;
    logic       flush_last;
  } result_t;

  // Shadow copy of the frame store and the dirty rectangle
  logic [7:0]        shadow_store [STORE_DEPTH];
  logic              dirty_pend;
  logic signed [9:0] rect_left;
  logic signed [7:0] rect_top;
  logic signed [10:0] rect_right;
  logic signed [8:0] rect_bottom;

  // Flush walk: byte cursor within the row, span, first byte, unit, rows
  int   fl_cursor, fl_span, fl_first, fl_unit, fl_line, fl_bottom;
  logic fl_active;

  result_t owed_results[$];

  function automatic logic [ADDR_W-1:0] store_addr(int row, int col);
    return ADDR_W'((row * ROW_BYTES + col) % STORE_DEPTH);
  endfunction

  // Apply one request to the shadow state and return the result it owes
  function automatic result_t frame_op_result(logic [2:0] func, logic signed [9:0] x,
                                              logic signed [7:0] y, logic signed [9:0] w,
                                              logic signed [7:0] h, logic [3:0] pv);
    result_t           r;
    int                xi, yi, wi, hgt, ri, bi, x0, y0, x1, y1, bstart, bend;
    logic [ADDR_W-1:0] a;
    r   = '0;
    xi  = x;
    yi  = y;
    wi  = w;
    hgt = h;
    case (func)
      FUNC_WRITE, FUNC_READ: begin
        if (xi < 0 || xi >= SCREEN_WIDTH || yi < 0 || yi >= SCREEN_HEIGHT) begin
          r.status = ST_RANGE;
        end else begin
          a = store_addr(yi, xi / 2);
          if (func == FUNC_WRITE) begin
            // even column lives in the high nibble
            if (xi[0] == 1'b0) shadow_store[a] = {pv, shadow_store[a][3:0]};
            else shadow_store[a] = {shadow_store[a][7:4], pv};
          end else begin
            r.read_pixel = xi[0] ? shadow_store[a][3:0] : shadow_store[a][7:4];
          end
        end
      end
      FUNC_MARK: begin
        // drop nonpositive sizes, else set fresh or grow the pending rectangle
        if (wi > 0 && hgt > 0) begin
          ri = xi + wi - 1;
          bi = yi + hgt - 1;
          if (!dirty_pend) begin
            dirty_pend  = 1'b1;
            rect_left   = x;
            rect_top    = y;
            rect_right  = 11'(ri);
            rect_bottom = 9'(bi);
          end else begin
            if (rect_left > x) rect_left = x;
            if (rect_top > y) rect_top = y;
            if (rect_right < ri) rect_right = 11'(ri);
            if (rect_bottom < bi) rect_bottom = 9'(bi);
          end
        end
      end
      FUNC_START: begin
        if (!dirty_pend) begin
          r.status = ST_EMPTY;
        end else begin
          dirty_pend = 1'b0;
          x0 = (rect_left < 0) ? 0 : rect_left;
          y0 = (rect_top < 0) ? 0 : rect_top;
          x1 = (rect_right > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : rect_right;
          y1 = (rect_bottom > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : rect_bottom;
          if (x0 > x1 || y0 > y1) begin
            fl_active = 1'b0;
            r.status  = ST_EMPTY;
          end else begin
            // round left edge to four pixels, widen span to an even byte count
            fl_unit = x0 / 4;
            bstart  = fl_unit * 2;
            bend    = x1 / 2;
            if (((bend - bstart) & 1) == 0) bend++;
            fl_first  = bstart;
            fl_span   = bend - bstart + 1;
            fl_cursor = 0;
            fl_line   = y0;
            fl_bottom = y1;
            fl_active = 1'b1;
          end
        end
      end
      FUNC_NEXT: begin
        if (!fl_active) begin
          r.status = ST_EMPTY;
        end else begin
          r.byte_valid  = 1'b1;
          r.flush_row   = fl_line[5:0];
          r.column_unit = fl_unit[5:0];
          r.flush_byte  = shadow_store[store_addr(fl_line, fl_first + fl_cursor)];
          r.row_start   = (fl_cursor == 0);
          r.flush_last  = (fl_cursor + 1 == fl_span) && (fl_line == fl_bottom);
          fl_cursor++;
          if (fl_cursor >= fl_span) begin
            fl_cursor = 0;
            fl_line++;
            if (fl_line > fl_bottom) fl_active = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.dirty_flag = dirty_pend;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got_v, int want_v);
    fail_count++;
    if (fail_count <= 20)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got_v, want_v);
  endtask

  // Compare each returned result first, then queue what a new request owes
  always @(posedge clk) begin : watch_channels
    result_t got, want;
    if (rst) begin
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      dirty_pend  = 1'b0;
      rect_left   = '0;
      rect_top    = '0;
      rect_right  = '0;
      rect_bottom = '0;
      fl_cursor   = 0;
      fl_span     = 0;
      fl_first    = 0;
      fl_unit     = 0;
      fl_line     = 0;
      fl_bottom   = 0;
      fl_active   = 1'b0;
      fail_count  = 0;
      owed_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[6], m_axis_tdata[7],
               m_axis_tdata[13:8], m_axis_tdata[19:14], m_axis_tdata[27:20],
               m_axis_tdata[28], m_axis_tlast};
        if (owed_results.size() == 0) begin
          report_mismatch("result with no request owed, tdata", m_axis_tdata, 0);
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.read_pixel !== want.read_pixel)
            report_mismatch("read_pixel", got.read_pixel, want.read_pixel);
          if (got.dirty_flag !== want.dirty_flag)
            report_mismatch("dirty_flag", got.dirty_flag, want.dirty_flag);
          if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
          if (got.flush_row !== want.flush_row)
            report_mismatch("flush_row", got.flush_row, want.flush_row);
          if (got.column_unit !== want.column_unit)
            report_mismatch("column_unit", got.column_unit, want.column_unit);
          if (got.flush_byte !== want.flush_byte)
            report_mismatch("flush_byte", got.flush_byte, want.flush_byte);
          if (got.row_start !== want.row_start)
            report_mismatch("row_start", got.row_start, want.row_start);
          if (got.flush_last !== want.flush_last)
            report_mismatch("flush_last", got.flush_last, want.flush_last);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        owed_results.push_back(frame_op_result(s_axis_tuser, s_axis_tdata[9:0],
                                               s_axis_tdata[17:10], s_axis_tdata[27:18],
                                               s_axis_tdata[35:28], s_axis_tdata[39:36]));
    end
    owed_count = owed_results.size();
  end

endmodule

### tb/nibble_framebuffer_dirty_flush_tb.sv
module nibble_framebuffer_dirty_flush_tb;
  import nfdf_pkg::*;

  // code outside the defined operations, expected to do nothing
  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam int         ITEM_COUNT  = 1700;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // x_pos, y_pos, width, height, pixel_value
  logic [2:0]  s_axis_tuser;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // status, read_pixel, dirty_flag, byte_valid,
                               // flush_row, column_unit, flush_byte, row_start
  logic        m_axis_tlast;   // flush_last
  int          fail_count;
  int          owed_count;
  int          sent_items;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;

  nibble_framebuffer_dirty_flush dut (.*);

  nfdf_result_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up well past the slowest legal run
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one request, maybe after an idle burst, and hold it until accepted
  task automatic send_request(logic [2:0] func, int x, int y, int w, int h, int pv);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {pv[3:0], h[7:0], w[9:0], y[7:0], x[9:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_items++;
  endtask

  // Stop offering and wait until every owed result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (owed_count == 0);
    @(posedge clk);
  endtask

  // One typical use: paint near a rectangle, mark it, flush it, plus some noise
  task automatic run_scene();
    int x0, y0, w, h, nxt;
    x0 = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 40)) - 20
                                     : int'($urandom_range(0, 255));
    y0 = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 70)) - 3
                                     : int'($urandom_range(0, 63));
    if ($urandom_range(0, 40) == 0) begin
      w = $urandom_range(64, 256);
      h = $urandom_range(1, 2);
    end else begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 4);
    end
    repeat ($urandom_range(2, 8))
      send_request(FUNC_WRITE, x0 + int'($urandom_range(0, w + 1)) - 1,
                   y0 + int'($urandom_range(0, h)), $urandom, $urandom, $urandom);
    repeat ($urandom_range(0, 3))
      send_request(FUNC_READ, x0 + int'($urandom_range(0, w + 1)) - 1,
                   y0 + int'($urandom_range(0, h)), $urandom, $urandom, $urandom);
    if ($urandom_range(0, 7) == 0)
      send_request(FUNC_MARK, x0, y0, -int'($urandom_range(0, 512)), $urandom, $urandom);
    send_request(FUNC_MARK, x0, y0, w, h, $urandom);
    if ($urandom_range(0, 3) == 0)
      send_request(FUNC_MARK, x0 + int'($urandom_range(0, 20)) - 10,
                   y0 + int'($urandom_range(0, 4)) - 2, $urandom_range(1, 12),
                   $urandom_range(1, 3), $urandom);
    if ($urandom_range(0, 19) != 0)
      send_request(FUNC_START, $urandom, $urandom, $urandom, $urandom, $urandom);
    // roughly the byte count; sometimes cut short so the next start replaces it
    nxt = ((w + 7) / 4 * 2) * h + int'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) nxt = nxt / 2;
    repeat (nxt) send_request(FUNC_NEXT, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4))
        send_request(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom,
                     $urandom);
  endtask

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_WRITE;
    sent_items    = 0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // pixel writes and reads at the corners and off screen
    send_request(FUNC_WRITE, 0, 0, 0, 0, 15);
    send_request(FUNC_WRITE, 1, 0, 0, 0, 10);
    send_request(FUNC_WRITE, 255, 63, 0, 0, 5);
    send_request(FUNC_WRITE, -1, 0, 0, 0, 3);
    send_request(FUNC_WRITE, 256, 0, 0, 0, 3);
    send_request(FUNC_WRITE, 511, -128, 511, 127, 15);
    send_request(FUNC_READ, 0, 64, 0, 0, 0);
    send_request(FUNC_READ, -512, 127, -512, -128, 0);
    send_request(FUNC_READ, 0, 0, 0, 0, 0);
    send_request(FUNC_READ, 1, 0, 0, 0, 0);
    send_request(FUNC_READ, 255, 63, 0, 0, 0);
    // next byte with no flush, start with nothing pending, ignored size
    send_request(FUNC_NEXT, 0, 0, 0, 0, 0);
    send_request(FUNC_START, 0, 0, 0, 0, 0);
    send_request(FUNC_MARK, 0, 0, -512, 5, 0);
    // two-pixel rectangle widens to a two-byte span
    send_request(FUNC_MARK, 0, 0, 2, 2, 0);
    send_request(FUNC_START, 0, 0, 0, 0, 0);
    repeat (4) send_request(FUNC_NEXT, 0, 0, 0, 0, 0);
    // rectangle entirely right of the screen
    send_request(FUNC_MARK, 300, 0, 10, 10, 0);
    send_request(FUNC_START, 0, 0, 0, 0, 0);
    // merged oversize rectangle, then a restart mid flush at the last row
    send_request(FUNC_MARK, 250, 60, 511, 127, 0);
    send_request(FUNC_MARK, -512, -128, 1, 1, 0);
    send_request(FUNC_START, 0, 0, 0, 0, 0);
    send_request(FUNC_NEXT, 0, 0, 0, 0, 0);
    send_request(FUNC_MARK, 254, 63, 2, 1, 0);
    send_request(FUNC_START, 0, 0, 0, 0, 0);
    repeat (2) send_request(FUNC_NEXT, 0, 0, 0, 0, 0);
    send_request(FUNC_UNUSED, 0, 0, 0, 0, 0);
    drain();

    while (sent_items < ITEM_COUNT) begin
      if (sent_items > ITEM_COUNT - 150) quiet = 1'b1;
      if (sent_items > 600 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (sent_items > 1000 && sent_items < 1030) drain();
      run_scene();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && owed_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/nfdf_pkg.sv
rtl/core/nfdf_ram.sv
rtl/core/nfdf_front.sv
rtl/core/nfdf_back.sv
rtl/core/nibble_framebuffer_dirty_flush.sv
tb/nfdf_result_checker.sv
tb/nibble_framebuffer_dirty_flush_tb.sv
